// File: design/abec_pkg.sv
// ----------------------------------------------------------------------------
// abec_pkg
// Shared types and codes for the access button and tag enrollment controller.
// ----------------------------------------------------------------------------
package abec_pkg;

   // modes reported with each tick
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_DOOR   = 2'd1;
   localparam logic [1:0] MODE_HOLD   = 2'd2;
   localparam logic [1:0] MODE_ENROLL = 2'd3;

   // event codes
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_DOOR    = 3'd1;
   localparam logic [2:0] EV_ENROLL  = 3'd2;
   localparam logic [2:0] EV_SAVED   = 3'd3;
   localparam logic [2:0] EV_DUP     = 3'd4;
   localparam logic [2:0] EV_FULL    = 3'd5;
   localparam logic [2:0] EV_TIMEOUT = 3'd6;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_HOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENROLL_WIN  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_OPEN   = 2'd3;

   // field widths
   localparam int unsigned HOLD_W  = 10;
   localparam int unsigned PHASE_W = 12;
   localparam int unsigned TAG_W   = 32;
   localparam int unsigned REQ_W   = 40;   // 34 bits of fields padded to bytes
   localparam int unsigned RSP_W   = 8;    // 7 bits of fields padded to bytes

   // entry 0 of the tag table, fixed at reset and never overwritten
   localparam logic [TAG_W-1:0] TAG_MASTER = 32'hDEADBEEF;

   typedef struct packed {
      logic load_in;     // latch the accepted request
      logic srch_start;  // clear search index and duplicate flag
      logic srch_rd;     // read table entry at search index
      logic srch_cmp;    // compare read entry, advance index
      logic commit;      // update state and load the result register
   } cmd_type;

   typedef struct packed {
      logic need_search; // enroll attempt with room left in the table
      logic srch_match;  // entry under compare equals the tag
      logic srch_last;   // entry under compare is the last filled one
      logic rsp_free;    // result register may be loaded this cycle
   } status_type;

endpackage

// File: design/abec_ctrl.sv
// ----------------------------------------------------------------------------
// abec_ctrl
// Sequencer: takes a request, runs the duplicate search when enrolling and
// commits the tick once the result register is free.
// ----------------------------------------------------------------------------
module abec_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  abec_pkg::status_type sts,
   output abec_pkg::cmd_type    cmd
);
   import abec_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.srch_start = 1'b1;
            state_in       = sts.need_search ? S_READ : S_COMMIT;
         end
         S_READ: begin
            cmd.srch_rd = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            cmd.srch_cmp = 1'b1;
            state_in     = (sts.srch_match || sts.srch_last) ? S_COMMIT : S_READ;
         end
         S_COMMIT: begin
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_cmp |-> $past(cmd.srch_rd))
      else $error("compare without a preceding table read");

   a_commit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.rsp_free)
      else $error("commit while result register occupied");

   a_one_hot_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

endmodule

// File: design/abec_datapath.sv
// ----------------------------------------------------------------------------
// abec_datapath
// Configuration, tick state, tag table with its search, and result register.
// ----------------------------------------------------------------------------
module abec_datapath #(
   parameter int unsigned TAG_ENTRIES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [abec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abec_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [abec_pkg::REQ_W-1:0]           req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [abec_pkg::RSP_W-1:0]           rsp_tdata,
   input  abec_pkg::cmd_type                    cmd,
   output abec_pkg::status_type                 sts
);
   import abec_pkg::*;

   localparam int unsigned IDX_W = (TAG_ENTRIES > 1) ? $clog2(TAG_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TAG_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TAG_ENTRIES);
   localparam logic [HOLD_W-1:0] HOLD_SAT = '1;

   // configuration
   logic [HOLD_W-1:0]  long_hold_ff, short_press_ff, door_open_ff;
   logic [PHASE_W-1:0] enroll_win_ff;

   // tick state
   logic [1:0]         mode_ff, mode_in;
   logic [HOLD_W-1:0]  hold_ff, hold_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               lamp_ff, lamp_in;
   logic [CNT_W-1:0]   count_ff;

   // latched request
   logic               door_ff, lamp_btn_ff;
   logic [TAG_W-1:0]   tag_ff;

   // search
   logic [TAG_W-1:0]   table_mem [TAG_ENTRIES];
   logic [TAG_W-1:0]   rd_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               dup_ff;
   logic [TAG_W-1:0]   cmp_entry;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_door_ff, rsp_lamp_ff;
   logic [1:0]         rsp_mode_ff;
   logic [2:0]         rsp_ev_ff;

   logic               door_out;
   logic [2:0]         ev;
   logic               do_save;
   logic               full;
   logic [HOLD_W-1:0]  hold_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_hold_ff   <= HOLD_W'(300);
         short_press_ff <= HOLD_W'(50);
         enroll_win_ff  <= PHASE_W'(1000);
         door_open_ff   <= HOLD_W'(300);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LONG_HOLD:   long_hold_ff   <= csr_data[HOLD_W-1:0];
            CSR_SHORT_PRESS: short_press_ff <= csr_data[HOLD_W-1:0];
            CSR_ENROLL_WIN:  enroll_win_ff  <= csr_data[PHASE_W-1:0];
            CSR_DOOR_OPEN:   door_open_ff   <= csr_data[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         door_ff     <= req_tdata[0];
         lamp_btn_ff <= req_tdata[1];
         tag_ff      <= req_tdata[TAG_W+1:2];
      end
   end

   assign full = (count_ff >= CNT_MAX);

   // entry 0 holds the master tag for good, so it is never taken from memory
   assign cmp_entry = (idx_ff == '0) ? TAG_MASTER : rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.srch_rd) begin
         rd_ff <= table_mem[idx_ff];
      end
      if (do_save) begin
         table_mem[count_ff[IDX_W-1:0]] <= tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.srch_start) begin
         idx_ff <= '0;
         dup_ff <= 1'b0;
      end else if (cmd.srch_cmp) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (cmp_entry == tag_ff) begin
            dup_ff <= 1'b1;
         end
      end
   end

   assign sts.need_search = (mode_ff == MODE_ENROLL) && door_ff && !full;
   assign sts.srch_match  = (cmp_entry == tag_ff);
   assign sts.srch_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.rsp_free    = !rsp_valid_ff || rsp_tready;

   assign hold_inc = (hold_ff != HOLD_SAT) ? hold_ff + HOLD_W'(1) : hold_ff;

   // one tick of the button logic, evaluated on the latched request
   always_comb begin
      mode_in  = mode_ff;
      hold_in  = hold_ff;
      phase_in = phase_ff;
      lamp_in  = lamp_ff;
      door_out = 1'b0;
      ev       = EV_NONE;
      do_save  = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (door_ff) begin
               mode_in  = MODE_DOOR;
               phase_in = (door_open_ff != '0) ?
                          PHASE_W'(door_open_ff - HOLD_W'(1)) : '0;
               door_out = 1'b1;
               ev       = EV_DOOR;
            end else if (lamp_btn_ff) begin
               hold_in = hold_inc;
               if (hold_inc > long_hold_ff) begin
                  mode_in = MODE_HOLD;
                  ev      = EV_ENROLL;
               end
            end else begin
               if ((hold_ff != '0) && (hold_ff < short_press_ff)) begin
                  lamp_in = !lamp_ff;
               end
               hold_in = '0;
            end
         end
         MODE_DOOR: begin
            if (phase_ff != '0) begin
               phase_in = phase_ff - PHASE_W'(1);
               door_out = 1'b1;
            end else if (!door_ff) begin
               mode_in = MODE_IDLE;
            end
         end
         MODE_HOLD: begin
            if (!lamp_btn_ff) begin
               mode_in  = MODE_ENROLL;
               phase_in = enroll_win_ff;
            end
         end
         default: begin
            if (door_ff) begin
               mode_in = MODE_IDLE;
               hold_in = '0;
               if (full) begin
                  ev = EV_FULL;
               end else if (dup_ff) begin
                  ev = EV_DUP;
               end else begin
                  ev      = EV_SAVED;
                  do_save = cmd.commit;
               end
            end else if (phase_ff <= PHASE_W'(1)) begin
               phase_in = '0;
               ev       = EV_TIMEOUT;
               mode_in  = MODE_IDLE;
               hold_in  = '0;
            end else begin
               phase_in = phase_ff - PHASE_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         hold_ff  <= '0;
         phase_ff <= '0;
         lamp_ff  <= 1'b1;
         count_ff <= CNT_W'(1);
      end else if (cmd.commit) begin
         mode_ff  <= mode_in;
         hold_ff  <= hold_in;
         phase_ff <= phase_in;
         lamp_ff  <= lamp_in;
         if (do_save) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_door_ff <= door_out;
         rsp_lamp_ff <= lamp_in;
         rsp_mode_ff <= mode_in;
         rsp_ev_ff   <= ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ev_ff, rsp_mode_ff, rsp_lamp_ff, rsp_door_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNT_MAX))
      else $error("tag count out of range");

   a_door_in_door_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_door_ff) |-> (rsp_mode_ff == MODE_DOOR))
      else $error("door relay active outside door mode");

   a_save_grows_count: assert property (@(posedge clock) disable iff (reset)
      do_save |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("saved tag did not advance the count");

endmodule

// File: design/access_button_enroll_controller.sv
// ----------------------------------------------------------------------------
// access_button_enroll_controller
// Door pulse, lamp toggle and tag enrollment, stepped once per request.
//
//   channel  direction  contents
//   req_     in         door_pressed, lamp_pressed, tag_id
//   rsp_     out        door_active, lamp_level, mode, event_res
//   csr_     in         register index and write data
//
// A request passes through evaluation and commit after acceptance; an enrollment
// attempt with room in the table also searches the filled entries, reading
// one entry at a time (read, then compare) through the single memory read port.
// Reset is synchronous; afterwards the block accepts requests at once.
// A new request is taken while the previous result waits; a stalled result
// holds the commit of the next one, and req_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module access_button_enroll_controller #(
   parameter int unsigned TAG_ENTRIES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] door_pressed, [1] lamp_pressed, [33:2] tag_id
   input  logic [abec_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] door_active, [1] lamp_level, [3:2] mode, [6:4] event_res
   output logic [abec_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [abec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [abec_pkg::CSR_DATA_W-1:0]  csr_data
);
   import abec_pkg::*;

   cmd_type    cmd;
   status_type sts;

   assign csr_ready = !reset;

   abec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   abec_datapath #(
      .TAG_ENTRIES (TAG_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: test/tb_access_button_enroll_controller.sv
// ----------------------------------------------------------------------------
// tb_access_button_enroll_controller
// Self-checking bench for the door, lamp and tag enrollment controller. Tick
// requests are driven through the req_ stream and every result is checked
// against a cycle-free model of the controller. Several register settings are
// used, the range limits among them. Both stream sides idle at random, but for the last setting.
// ----------------------------------------------------------------------------
module tb_access_button_enroll_controller;
   import abec_pkg::*;

   localparam int unsigned TAG_ENTRIES   = 8;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef struct {
      logic       door_active;
      logic       lamp_level;
      logic [1:0] mode;
      logic [2:0] event_res;
   } tick_result_type;

   // Model of the controller, one step per accepted request.
   class button_tick_checker;
      logic [HOLD_W-1:0]  long_hold;
      logic [HOLD_W-1:0]  short_max;
      logic [PHASE_W-1:0] window;
      logic [HOLD_W-1:0]  door_open;
      logic [1:0]         mode;
      logic [HOLD_W-1:0]  hold;
      logic [PHASE_W-1:0] phase;
      logic               lamp;
      logic [TAG_W-1:0]   tags [TAG_ENTRIES];
      int unsigned        tag_count;
      tick_result_type    expected_ticks [$];
      int unsigned        errors;

      function new();
         int i;
         long_hold = 10'd300;
         short_max = 10'd50;
         window    = 12'd1000;
         door_open = 10'd300;
         mode      = MODE_IDLE;
         hold      = '0;
         phase     = '0;
         lamp      = 1'b1;
         for (i = 0; i < TAG_ENTRIES; i++) tags[i] = '0;
         tags[0]   = TAG_MASTER;
         tag_count = 1;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_LONG_HOLD:   long_hold = data[HOLD_W-1:0];
            CSR_SHORT_PRESS: short_max = data[HOLD_W-1:0];
            CSR_ENROLL_WIN:  window    = data;
            default:         door_open = data[HOLD_W-1:0];
         endcase
      endfunction

      function logic [2:0] store_tag(logic [TAG_W-1:0] id);
         int i;
         if (tag_count >= TAG_ENTRIES) return EV_FULL;
         for (i = 0; i < tag_count; i++) begin
            if (tags[i] == id) return EV_DUP;
         end
         tags[tag_count] = id;
         tag_count++;
         return EV_SAVED;
      endfunction

      function void note_request(logic door_btn, logic lamp_btn, logic [TAG_W-1:0] id);
         tick_result_type res;
         res.door_active = 1'b0;
         res.event_res   = EV_NONE;
         case (mode)
            MODE_IDLE: begin
               if (door_btn) begin
                  mode  = MODE_DOOR;
                  phase = (door_open != 0) ? PHASE_W'(door_open) - 1'b1 : '0;
                  res.door_active = 1'b1;
                  res.event_res   = EV_DOOR;
               end else if (lamp_btn) begin
                  if (hold != 10'd1023) hold++;
                  if (hold > long_hold) begin
                     mode = MODE_HOLD;
                     res.event_res = EV_ENROLL;
                  end
               end else begin
                  if (hold != 0 && hold < short_max) lamp = ~lamp;
                  hold = '0;
               end
            end
            MODE_DOOR: begin
               if (phase != 0) begin
                  phase--;
                  res.door_active = 1'b1;
               end else if (!door_btn) begin
                  mode = MODE_IDLE;
               end
            end
            MODE_HOLD: begin
               if (!lamp_btn) begin
                  mode  = MODE_ENROLL;
                  phase = window;
               end
            end
            default: begin
               if (door_btn) begin
                  res.event_res = store_tag(id);
                  mode = MODE_IDLE;
                  hold = '0;
               end else if (phase <= 1) begin
                  phase = '0;
                  res.event_res = EV_TIMEOUT;
                  mode = MODE_IDLE;
                  hold = '0;
               end else begin
                  phase--;
               end
            end
         endcase
         res.lamp_level = lamp;
         res.mode       = mode;
         expected_ticks.push_back(res);
      endfunction

      function void compare_field(string name, int unsigned exp_val, int unsigned got_val);
         if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_W-1:0] data);
         tick_result_type res;
         if (expected_ticks.size() == 0) begin
            $error("result with no request outstanding: %h", data);
            errors++;
            return;
         end
         res = expected_ticks.pop_front();
         compare_field("door_active", res.door_active, data[0]);
         compare_field("lamp_level", res.lamp_level, data[1]);
         compare_field("mode", res.mode, data[3:2]);
         compare_field("event_res", res.event_res, data[6:4]);
      endfunction

      function int unsigned pending();
         return expected_ticks.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = CSR_LONG_HOLD;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   button_tick_checker sb = new();
   bit          idle_on = 1'b1;
   int unsigned sent    = 0;

   access_button_enroll_controller #(
      .TAG_ENTRIES (TAG_ENTRIES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // handshakes are observed here only, so the model follows the bus
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(req_tdata[0], req_tdata[1], req_tdata[33:2]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // result side back-pressure
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) stall--;
         else if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
         rsp_tready <= (stall == 0);
      end
   end

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_tick(input logic door_btn, input logic lamp_btn,
                            input logic [TAG_W-1:0] tag_val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, tag_val, lamp_btn, door_btn};
      do @(posedge clock); while (!req_tready);
      sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [CSR_DATA_W-1:0] lh, input logic [CSR_DATA_W-1:0] sp,
                                 input logic [CSR_DATA_W-1:0] ew, input logic [CSR_DATA_W-1:0] dop);
      logic [CSR_IDX_W-1:0]  idx  [4];
      logic [CSR_DATA_W-1:0] vals [4];
      int i;
      idx  = '{CSR_LONG_HOLD, CSR_SHORT_PRESS, CSR_ENROLL_WIN, CSR_DOOR_OPEN};
      vals = '{lh, sp, ew, dop};
      for (i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // known tags give duplicates, the rest fill the table until it is full
   function automatic logic [TAG_W-1:0] pick_tag();
      case ($urandom_range(0, 5))
         0, 1:    return sb.tags[$urandom_range(0, sb.tag_count - 1)];
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // drive until the controller is back in idle
   task automatic settle();
      while (sb.mode != MODE_IDLE) begin
         case (sb.mode)
            MODE_DOOR: begin
               if (sb.phase != 0)
                  send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
               else
                  send_tick($urandom_range(0, 2) == 0, 1'b0, $urandom);
            end
            MODE_HOLD: send_tick(1'b0, 1'($urandom_range(0, 1)), $urandom);
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  send_tick(1'b1, 1'($urandom_range(0, 1)), pick_tag());
                  // door still held after enrolling opens the door
                  if ($urandom_range(0, 1) == 0) send_tick(1'b1, 1'b0, $urandom);
               end else begin
                  send_tick(1'b0, 1'($urandom_range(0, 1)), $urandom);
               end
            end
         endcase
      end
   endtask

   task automatic run_episodes(input int unsigned count);
      int unsigned target;
      int unsigned sel;
      int unsigned n;
      bit          door_ok;
      target = sent + count;
      while (sent < target) begin
         sel     = $urandom_range(0, 19);
         door_ok = (sb.door_open <= 50);
         if (sel < 5 && door_ok) begin
            send_tick(1'b1, 1'($urandom_range(0, 1)), pick_tag());
         end else if (sel < 10) begin
            n = $urandom_range(1, (sb.short_max < 12) ? sb.short_max + 1 : 12);
            repeat (n) send_tick(1'b0, 1'b1, $urandom);
            send_tick(1'b0, 1'b0, $urandom);
         end else if (sel < 17) begin
            n = (sb.long_hold < 100) ? sb.long_hold + $urandom_range(1, 3)
                                     : $urandom_range(1, 20);
            repeat (n) send_tick(1'b0, 1'b1, $urandom);
         end else begin
            repeat ($urandom_range(1, 4))
               send_tick(door_ok & 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         $urandom);
         end
         settle();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: short presses toggle the lamp from its high level
      send_tick(1'b0, 1'b1, '0);
      send_tick(1'b0, 1'b0, '1);
      send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      wait_idle();

      write_settings(12'd3, 12'd3, 12'd3, 12'd2);
      // door wins over lamp, then pulse and release wait
      send_tick(1'b1, 1'b1, '0);
      send_tick(1'b0, 1'b0, $urandom);
      send_tick(1'b1, 1'b0, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      // long hold, enroll the master tag (duplicate), door still held
      repeat (5) send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      send_tick(1'b1, 1'b0, TAG_MASTER);
      send_tick(1'b1, 1'b0, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      // new tag saved
      repeat (4) send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      send_tick(1'b1, 1'b1, '1);
      send_tick(1'b0, 1'b0, $urandom);
      // window runs out
      repeat (4) send_tick(1'b0, 1'b1, $urandom);
      repeat (4) send_tick(1'b0, 1'b0, $urandom);
      // count of one toggles, count equal to the limit does not
      send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      repeat (3) send_tick(1'b0, 1'b1, $urandom);
      send_tick(1'b0, 1'b0, $urandom);
      run_episodes(100);
      wait_idle();

      write_settings(12'd1, 12'd1, 12'd1, 12'd1);
      run_episodes(70);
      wait_idle();

      // upper register limits: a long hold of the maximum never enrolls
      write_settings(12'd1023, 12'd1023, 12'd4095, 12'd1);
      run_episodes(60);
      wait_idle();

      write_settings(12'd2, 12'd5, 12'd4095, 12'd40);
      run_episodes(60);
      send_tick(1'b1, 1'b0, $urandom);
      settle();
      wait_idle();

      idle_on = 1'b0;
      write_settings(12'd6, 12'd4, 12'd7, 12'd3);
      run_episodes(70);
      wait_idle();

      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
